// File: hw/rtl/cuq_pkg.sv
`default_nettype none

package cuq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ENTRIES = 1'b0,
        REG_MAX_BYTES   = 1'b1
    } cfg_reg_t;

    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [31:0] MAX_BYTES_RST   = 32'd16777216;

    localparam logic [1:0] CMD_ENQUEUE      = 2'd0;
    localparam logic [1:0] CMD_DRAIN        = 2'd1;
    localparam logic [1:0] CMD_CLEAR_RESYNC = 2'd2;

    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_CREATE  = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;
    localparam logic [1:0] KIND_RESYNC  = 2'd3;

    typedef enum logic [1:0] {
        OP_ENQUEUE,
        OP_DRAIN,
        OP_CLEAR,
        OP_NOP
    } op_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } back_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  update_kind;
        logic [31:0] image_id;
        logic [31:0] payload_bytes;
        logic [31:0] payload_handle;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_sequence;
        logic        entry_valid;
        logic [1:0]  entry_kind;
        logic [31:0] entry_image;
        logic [31:0] entry_bytes;
        logic [31:0] entry_handle;
        logic        last;
        logic        resync_pending;
        logic [31:0] queued_total;
    } out_item_t;

    // classified transaction handed from front to back
    typedef struct packed {
        op_code_t    op;
        logic [1:0]  kind;
        logic [31:0] image;
        logic [31:0] bytes;
        logic [31:0] handle;
    } queue_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] image;
        logic [31:0] seq;
        logic [31:0] bytes;
        logic [31:0] handle;
    } entry_t;

    function automatic logic is_image_kind(input logic [1:0] k);
        return (k == KIND_CREATE) || (k == KIND_REPLACE);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cuq_front.sv
`default_nettype none

module cuq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire cuq_pkg::in_item_t  in_data,
    output logic                    op_valid,
    input  wire logic               op_take,
    output cuq_pkg::queue_op_t      op_data
);
    import cuq_pkg::*;

    queue_op_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    queue_op_t  decoded;

    always_comb
    begin
        decoded.image  = in_data.image_id;
        decoded.bytes  = in_data.payload_bytes;
        decoded.handle = in_data.payload_handle;
        // a resync kind on input is just an ordinary update
        decoded.kind   = (in_data.update_kind == KIND_RESYNC) ? KIND_OTHER
                                                              : in_data.update_kind;
        unique case (in_data.command)
            CMD_ENQUEUE:      decoded.op = OP_ENQUEUE;
            CMD_DRAIN:        decoded.op = OP_DRAIN;
            CMD_CLEAR_RESYNC: decoded.op = OP_CLEAR;
            default:          decoded.op = OP_NOP;
        endcase
    end

    assign in_stall = (fill_reg == 2'd2);
    assign op_valid = (fill_reg != 2'd0);
    assign op_data  = slot_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = op_valid && op_take;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cuq_back.sv
`default_nettype none

module cuq_back #(
    parameter int QUEUE_DEPTH = cuq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [4:0]         max_entries,
    input  wire logic [31:0]        max_bytes,
    input  wire logic               op_valid,
    output logic                    op_take,
    input  wire cuq_pkg::queue_op_t op_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cuq_pkg::out_item_t      out_data
);
    import cuq_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(QUEUE_DEPTH);

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       total_reg, total_next;
    logic [31:0]       seq_reg, seq_next;
    logic              flag_reg, flag_next;
    logic [CNT_W-1:0]  drain_left_reg, drain_left_next;
    entry_t            tail_reg, tail_next;
    queue_op_t         op_reg, op_next;
    logic              coal_reg, coal_next;
    logic              full_reg, full_next;
    logic [33:0]       rest_reg, rest_next;
    logic [32:0]       plus_reg, plus_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    entry_t            mem [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    logic              out_free;
    logic              take;
    logic [SUM_W-1:0]  push_sum;
    logic [ADDR_W-1:0] push_slot;
    logic [ADDR_W-1:0] head_inc;
    logic [31:0]       seq_inc;
    logic              fits;
    logic              overflow;

    assign out_free  = !out_valid_reg || !out_stall;
    assign op_take   = (state_reg == ST_IDLE)
                     && ((op_data.op == OP_ENQUEUE)
                         || ((op_data.op == OP_DRAIN) && (count_reg != '0))
                         || out_free);
    assign take      = op_valid && op_take;
    assign push_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign push_slot = (push_sum >= DEPTH_S) ? ADDR_W'(push_sum - DEPTH_S)
                                             : ADDR_W'(push_sum);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + ADDR_W'(1);
    assign seq_inc   = seq_reg + 32'd1;
    assign fits      = coal_reg && (rest_reg <= {2'b00, max_bytes});
    assign overflow  = full_reg || (total_reg > max_bytes)
                     || (plus_reg > {1'b0, max_bytes});

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (op_data.op == OP_ENQUEUE))
                begin
                    state_next = ST_ENQ;
                end
                else if (take && (op_data.op == OP_DRAIN) && (count_reg != '0))
                begin
                    state_next = ST_DRAIN_RD;
                end
            end
            ST_ENQ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_RD:
            begin
                state_next = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    state_next = (drain_left_reg == CNT_W'(1)) ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        seq_next        = seq_reg;
        flag_next       = flag_reg;
        drain_left_next = drain_left_reg;
        tail_next       = tail_reg;
        op_next         = op_reg;
        coal_next       = coal_reg;
        full_next       = full_reg;
        rest_next       = rest_reg;
        plus_next       = plus_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = push_slot;
        mem_wdata       = tail_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (op_data.op)
                        OP_ENQUEUE:
                        begin
                            op_next   = op_data;
                            coal_next = (count_reg != '0) && is_image_kind(op_data.kind)
                                      && is_image_kind(tail_reg.kind)
                                      && (tail_reg.image == op_data.image);
                            full_next = (CMP_W'(count_reg) >= CMP_W'(max_entries))
                                      || (CMP_W'(count_reg) >= DEPTH_C);
                            rest_next = {2'b00, total_reg} - {2'b00, tail_reg.bytes}
                                      + {2'b00, op_data.bytes};
                            plus_next = {1'b0, total_reg} + {1'b0, op_data.bytes};
                        end
                        OP_DRAIN:
                        begin
                            total_next = '0;
                            if (count_reg != '0)
                            begin
                                drain_left_next = count_reg;
                                count_next      = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                    // single-result transactions answer right away
                    if ((op_data.op == OP_CLEAR) || (op_data.op == OP_NOP)
                        || ((op_data.op == OP_DRAIN) && (count_reg == '0)))
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        out_next.last  = 1'b1;
                        out_next.resync_pending = flag_next;
                        out_next.queued_total   = total_next;
                    end
                end
            end
            ST_ENQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    if (flag_reg)
                    begin
                        seq_next                = seq_inc;
                        out_next.result_sequence = seq_inc;
                    end
                    else if (fits)
                    begin
                        // overwrite the tail, keep its sequence; a create stays a create
                        tail_next.kind   = (tail_reg.kind == KIND_CREATE) ? KIND_CREATE
                                                                          : op_reg.kind;
                        tail_next.bytes  = op_reg.bytes;
                        tail_next.handle = op_reg.handle;
                        total_next       = rest_reg[31:0];
                        mem_we           = 1'b1;
                        mem_waddr        = push_slot - ADDR_W'(1);
                        if (count_reg == CNT_W'(1) || push_slot == '0)
                        begin
                            mem_waddr = (push_slot == '0) ? LAST_SLOT
                                                          : push_slot - ADDR_W'(1);
                        end
                        out_next.result_sequence = tail_reg.seq;
                    end
                    else if (overflow)
                    begin
                        seq_next         = seq_inc;
                        flag_next        = 1'b1;
                        count_next       = CNT_W'(1);
                        total_next       = '0;
                        tail_next        = '0;
                        tail_next.kind   = KIND_RESYNC;
                        tail_next.seq    = seq_inc;
                        mem_we           = 1'b1;
                        mem_waddr        = head_reg;
                        out_next.result_sequence = seq_inc;
                    end
                    else
                    begin
                        seq_next         = seq_inc;
                        count_next       = count_reg + CNT_W'(1);
                        total_next       = plus_reg[31:0];
                        tail_next.kind   = op_reg.kind;
                        tail_next.image  = op_reg.image;
                        tail_next.seq    = seq_inc;
                        tail_next.bytes  = op_reg.bytes;
                        tail_next.handle = op_reg.handle;
                        mem_we           = 1'b1;
                        mem_waddr        = push_slot;
                        out_next.result_sequence = seq_inc;
                    end
                    mem_wdata = tail_next;
                    out_next.resync_pending = flag_next;
                    out_next.queued_total   = total_next;
                end
            end
            ST_DRAIN_RD:
            begin
            end
            ST_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.result_sequence = rd_data_reg.seq;
                    out_next.entry_valid     = 1'b1;
                    out_next.entry_kind      = rd_data_reg.kind;
                    out_next.entry_image     = rd_data_reg.image;
                    out_next.entry_bytes     = rd_data_reg.bytes;
                    out_next.entry_handle    = rd_data_reg.handle;
                    out_next.last            = (drain_left_reg == CNT_W'(1));
                    out_next.resync_pending  = flag_reg;
                    out_next.queued_total    = '0;
                    head_next                = head_inc;
                    drain_left_next          = drain_left_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            seq_reg        <= '0;
            flag_reg       <= 1'b0;
            drain_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            seq_reg        <= seq_next;
            flag_reg       <= flag_next;
            drain_left_reg <= drain_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        op_reg   <= op_next;
        coal_reg <= coal_next;
        full_reg <= full_next;
        rest_reg <= rest_next;
        plus_reg <= plus_next;
        out_reg  <= out_next;
    end

    // descriptor store: one write port, one registered read port at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head_reg];
    end

endmodule

`default_nettype wire

// File: hw/rtl/coalescing_update_queue_unit.sv
`default_nettype none

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------
// in        | input     | in_valid / in_stall | in_data   (in_item_t)
// out       | output    | out_valid/out_stall | out_data  (out_item_t)
// cfg       | input     | cfg_wr_en           | cfg_addr, cfg_wdata
//
// A two-entry queue decouples intake from execution; intake stalls only
// when it is full. The back end evaluates an enqueue, then commits it; it
// registers the result of a clear, no-op or empty drain as it takes it. A
// drain of n entries is taken, then each entry gets a registered read of
// the descriptor store and then the output.
// Reset clears all control state; the descriptor store needs no clearing.
// A stalled output holds its result; the back end waits on it.

module coalescing_update_queue_unit #(
    parameter int QUEUE_DEPTH = cuq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire cuq_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output cuq_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [cuq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [cuq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cuq_pkg::*;

    logic [4:0]  max_entries_reg;
    logic [31:0] max_bytes_reg;
    logic        op_valid;
    logic        op_take;
    queue_op_t   op_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            max_bytes_reg   <= MAX_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MAX_ENTRIES: max_entries_reg <= cfg_wdata[4:0];
                REG_MAX_BYTES:   max_bytes_reg   <= cfg_wdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    cuq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_take  (op_take),
        .op_data  (op_data)
    );

    cuq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_entries (max_entries_reg),
        .max_bytes   (max_bytes_reg),
        .op_valid    (op_valid),
        .op_take     (op_take),
        .op_data     (op_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    a_full_queue_has_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> op_valid)
        else $error("intake queue full but nothing offered to back end");

    a_plain_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.entry_valid) |-> out_data.last)
        else $error("result without an entry is not the last one");

    a_plain_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.entry_valid) |->
            (out_data.entry_kind == KIND_OTHER) && (out_data.entry_image == '0)
            && (out_data.entry_bytes == '0) && (out_data.entry_handle == '0))
        else $error("result without an entry carries entry fields");

    a_drain_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.entry_valid) |-> (out_data.queued_total == '0))
        else $error("drained entry reports nonzero byte total");

endmodule

`default_nettype wire
